### rtl/core/sha256_hash_engine_assert.svh
// Assertion macros for the SHA-256 hash engine.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA256_HASH_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SHA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SHA_ASSERT(lbl, prop, msg)
`define SHA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Word types, round constants and initial hash values for the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned NumChain  = 8;
  localparam int unsigned NumBlkWd  = 16;
  localparam int unsigned NumRounds = 64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [31:0] ROUND_K [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_256 [NumChain] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] IV_224 [NumChain] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### rtl/core/sha256_hash_engine.sv
// A byte word is taken in ST_IDLE; a word that fills a block starts compression:
// 64 rounds on the one shared round unit, then the chaining add.
// End of message: a padding step, compression of one or two blocks, then one digest
// word per cycle while out_stall_i is low. No byte word is taken while a block is busy.
// Reset (rst_ni low, asynchronous) selects SHA-256 and clears length and fill count.
// ----------------------------------------------------------------------------
// sha256_hash_engine
// Byte-fed SHA-256 / SHA-224 engine with one round unit reused over 64 rounds.
// ----------------------------------------------------------------------------
`include "sha256_hash_engine_assert.svh"

module sha256_hash_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha256_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sha256_pkg::out_item_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_COMP, ST_ADD, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_DATA, PH_LEN, PH_LAST
  } phase_e;

  state_e      state_q;
  phase_e      phase_q;
  logic        eom_q;
  logic        mode_q;
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;
  logic [2:0]  emit_q;
  logic [31:0] chain_q [sha256_pkg::NumChain];
  logic [31:0] v_q     [sha256_pkg::NumChain];
  logic [31:0] blk_q   [sha256_pkg::NumBlkWd];
  logic [31:0] blk_d   [sha256_pkg::NumBlkWd];
  logic        out_valid_q;
  sha256_pkg::out_item_t out_data_q;

  logic        in_acc;
  logic        cfg_acc;
  logic        last_emit;
  logic [31:0] big1, big0, ch, maj, t1, t2, sig0, sig1, w_new;
  logic [3:0]  pad_idx;

  // Hold off byte words while busy or while a mode write is offered
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign last_emit   = (emit_q == 3'd7) || (mode_q && (emit_q == 3'd6));
  assign pad_idx     = fill_q[5:2];

  // Round unit and message schedule on the sliding 16-word window
  always_comb begin
    big1  = sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
          ^ sha256_pkg::rotr(v_q[4], 25);
    ch    = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
    t1    = v_q[7] + big1 + ch + sha256_pkg::ROUND_K[rnd_q] + blk_q[0];
    big0  = sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
          ^ sha256_pkg::rotr(v_q[0], 22);
    maj   = (v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1]));
    t2    = big0 + maj;
    sig0  = sha256_pkg::rotr(blk_q[1], 7) ^ sha256_pkg::rotr(blk_q[1], 18)
          ^ (blk_q[1] >> 3);
    sig1  = sha256_pkg::rotr(blk_q[14], 17) ^ sha256_pkg::rotr(blk_q[14], 19)
          ^ (blk_q[14] >> 10);
    w_new = sig1 + blk_q[9] + sig0 + blk_q[0];
  end

  // Next block contents: byte write, padding, schedule shift, length block
  always_comb begin
    blk_d = blk_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.byte_valid) begin
          case (fill_q[1:0])
            2'd0:    blk_d[pad_idx] = {in_data_i.data_byte, 24'h0};
            2'd1:    blk_d[pad_idx] = blk_q[pad_idx] | {8'h0, in_data_i.data_byte, 16'h0};
            2'd2:    blk_d[pad_idx] = blk_q[pad_idx] | {16'h0, in_data_i.data_byte, 8'h0};
            default: blk_d[pad_idx] = blk_q[pad_idx] | {24'h0, in_data_i.data_byte};
          endcase
        end
      end
      ST_PAD: begin
        for (int j = 0; j < sha256_pkg::NumBlkWd; j++) begin
          if (4'(j) > pad_idx) begin
            blk_d[j] = '0;
          end
        end
        case (fill_q[1:0])
          2'd0:    blk_d[pad_idx] = {sha256_pkg::PadByte, 24'h0};
          2'd1:    blk_d[pad_idx] = blk_q[pad_idx] | {8'h0, sha256_pkg::PadByte, 16'h0};
          2'd2:    blk_d[pad_idx] = blk_q[pad_idx] | {16'h0, sha256_pkg::PadByte, 8'h0};
          default: blk_d[pad_idx] = blk_q[pad_idx] | {24'h0, sha256_pkg::PadByte};
        endcase
        if (fill_q[5:3] != 3'b111) begin
          blk_d[14] = len_q[63:32];
          blk_d[15] = len_q[31:0];
        end
      end
      ST_COMP: begin
        for (int j = 0; j < sha256_pkg::NumBlkWd - 1; j++) begin
          blk_d[j] = blk_q[j+1];
        end
        blk_d[15] = w_new;
      end
      ST_ADD: begin
        if (phase_q == PH_LEN) begin
          for (int j = 0; j < sha256_pkg::NumBlkWd; j++) begin
            blk_d[j] = '0;
          end
          blk_d[14] = len_q[63:32];
          blk_d[15] = len_q[31:0];
        end
      end
      default: ;
    endcase
  end

  // Hold the message block
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  // Sequencer, chaining words and output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_DATA;
      eom_q       <= 1'b0;
      mode_q      <= 1'b0;
      fill_q      <= '0;
      len_q       <= '0;
      rnd_q       <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      for (int j = 0; j < sha256_pkg::NumChain; j++) begin
        chain_q[j] <= sha256_pkg::IV_256[j];
        v_q[j]     <= '0;
      end
    end else begin
      // drop the word once taken, unless a new one is loaded below
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cfg_acc) begin
            mode_q <= cfg_data_i;
            fill_q <= '0;
            len_q  <= '0;
            for (int j = 0; j < sha256_pkg::NumChain; j++) begin
              chain_q[j] <= cfg_data_i ? sha256_pkg::IV_224[j] : sha256_pkg::IV_256[j];
            end
          end else if (in_acc) begin
            eom_q <= in_data_i.end_of_message;
            if (in_data_i.byte_valid) begin
              fill_q <= fill_q + 6'd1;
              len_q  <= len_q + 64'd8;
            end
            if (in_data_i.byte_valid && (fill_q == 6'd63)) begin
              phase_q <= PH_DATA;
              rnd_q   <= '0;
              v_q     <= chain_q;
              state_q <= ST_COMP;
            end else if (in_data_i.end_of_message) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          phase_q <= (fill_q[5:3] == 3'b111) ? PH_LEN : PH_LAST;
          rnd_q   <= '0;
          v_q     <= chain_q;
          state_q <= ST_COMP;
        end
        ST_COMP: begin
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          rnd_q  <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int j = 0; j < sha256_pkg::NumChain; j++) begin
            chain_q[j] <= chain_q[j] + v_q[j];
            v_q[j]     <= chain_q[j] + v_q[j];
          end
          rnd_q <= '0;
          case (phase_q)
            PH_DATA: state_q <= eom_q ? ST_PAD : ST_IDLE;
            PH_LEN: begin
              phase_q <= PH_LAST;
              state_q <= ST_COMP;
            end
            default: begin
              emit_q  <= '0;
              state_q <= ST_EMIT;
            end
          endcase
        end
        ST_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q            <= 1'b1;
            out_data_q.digest_word <= chain_q[emit_q];
            out_data_q.word_index  <= emit_q;
            out_data_q.last_word   <= last_emit;
            emit_q                 <= emit_q + 3'd1;
            if (last_emit) begin
              fill_q  <= '0;
              len_q   <= '0;
              eom_q   <= 1'b0;
              state_q <= ST_IDLE;
              for (int j = 0; j < sha256_pkg::NumChain; j++) begin
                chain_q[j] <= mode_q ? sha256_pkg::IV_224[j] : sha256_pkg::IV_256[j];
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `SHA_ASSERT(a_round_end,
    (state_q == ST_COMP && rnd_q == 6'd63) |=> (state_q == ST_ADD),
    "round 63 must end in chaining add")
  `SHA_ASSERT(a_last_index,
    (out_valid_o && out_data_o.last_word) |->
      (out_data_o.word_index == 3'd7 || out_data_o.word_index == 3'd6),
    "last digest word at wrong index")
  `SHA_ASSERT_NEVER(a_emit_phase,
    state_q == ST_EMIT && phase_q != PH_LAST,
    "digest emitted before length block")

endmodule
